/* src/sem_pkg.sv */
// Shared types and constants for the RGB Sobel edge-magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

   // Pixel and channel geometry
   localparam int unsigned CH_W   = 8;
   localparam int unsigned NUM_CH = 3;
   localparam int unsigned PIX_W  = CH_W * NUM_CH;
   localparam int unsigned LINE_W = 2 * PIX_W;   // {upper, middle} per column
   localparam int unsigned WIN_N  = 9;

   // Gradient and magnitude arithmetic
   localparam int unsigned GRAD_W     = 11;       // |g| <= 1020
   localparam int unsigned ABS_W      = 10;
   localparam int unsigned SQ_W       = 2 * ABS_W + 1;
   localparam int unsigned ROOT_W     = 8;
   localparam int unsigned SRC_W      = 2 * ROOT_W;
   localparam int unsigned REM_W      = 10;
   localparam int unsigned ROOT_STEPS = ROOT_W;
   localparam int unsigned STEP_W     = 3;
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
   // above 255*255+255 the rounded root is 256 or more
   localparam logic [SQ_W-1:0] SAT_LIMIT = SQ_W'(65280);
   localparam logic [ROOT_W-1:0] MAG_MAX = 8'd255;

   // Configuration registers
   localparam int unsigned WIDTH_REG_W  = 11;
   localparam int unsigned HEIGHT_REG_W = 13;
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   typedef logic [PIX_W-1:0] pix_type;           // blue, green, red (red low)
   typedef logic signed [GRAD_W-1:0] grad_type;

   typedef struct packed {
      logic            cmd;
      logic [CH_W-1:0] pixel_red;
      logic [CH_W-1:0] pixel_green;
      logic [CH_W-1:0] pixel_blue;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] edge_red;
      logic [CH_W-1:0] edge_green;
      logic [CH_W-1:0] edge_blue;
      logic            frame_end;
   } rsp_type;

   typedef struct packed {
      logic left_ok;
      logic right_ok;
      logic top_ok;
      logic bottom_ok;
   } win_mask_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic load;
      logic square;
      logic step;
   } mag_ctrl_type;

endpackage

/* src/sem_line_buf.sv */
// Line buffer memory: upper and middle line packed per column, registered read.
`timescale 1ns / 1ps

module sem_line_buf #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [sem_pkg::LINE_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [sem_pkg::LINE_W-1:0] wr_data
);
   import sem_pkg::*;

   logic [LINE_W-1:0] mem_ff [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sem_window.sv */
// 3x3 window registers and the masked Sobel Gx/Gy sums for each channel.
`timescale 1ns / 1ps

module sem_window (
   input  logic                  clock,
   input  logic                  reset,
   input  sem_pkg::win_ctrl_type ctrl,
   input  sem_pkg::pix_type      top_pix,
   input  sem_pkg::pix_type      mid_pix,
   input  sem_pkg::pix_type      new_pix,
   input  sem_pkg::win_mask_type mask,
   output sem_pkg::grad_type     gx [sem_pkg::NUM_CH],
   output sem_pkg::grad_type     gy [sem_pkg::NUM_CH]
);
   import sem_pkg::*;

   // index col*3 + row, col 0 left, row 0 top
   pix_type win_ff [WIN_N];

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int k = 0; k < WIN_N; k++) begin
            win_ff[k] <= '0;
         end
      end else if (ctrl.shift) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_ff[k+3];
         end
         win_ff[6] <= top_pix;
         win_ff[7] <= mid_pix;
         win_ff[8] <= new_pix;
      end
   end

   always_comb begin
      grad_type vv [WIN_N];
      logic     col_ok [3];
      logic     row_ok [3];
      col_ok[0] = mask.left_ok;
      col_ok[1] = 1'b1;
      col_ok[2] = mask.right_ok;
      row_ok[0] = mask.top_ok;
      row_ok[1] = 1'b1;
      row_ok[2] = mask.bottom_ok;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int k = 0; k < WIN_N; k++) begin
            vv[k] = (col_ok[k/3] && row_ok[k%3]) ?
                    GRAD_W'(win_ff[k][CH_W*ch +: CH_W]) : '0;
         end
         gx[ch] = (vv[6] + (vv[7] <<< 1) + vv[8]) - (vv[0] + (vv[1] <<< 1) + vv[2]);
         gy[ch] = (vv[2] + (vv[5] <<< 1) + vv[8]) - (vv[0] + (vv[3] <<< 1) + vv[6]);
      end
   end

endmodule

/* src/sem_mag.sv */
// Gradient magnitude lane: abs, sum of squares, bit-serial rounded root, clamp.
`timescale 1ns / 1ps

module sem_mag (
   input  logic                      clock,
   input  sem_pkg::mag_ctrl_type     ctrl,
   input  sem_pkg::grad_type         gx,
   input  sem_pkg::grad_type         gy,
   output logic [sem_pkg::ROOT_W-1:0] mag
);
   import sem_pkg::*;

   logic [ABS_W-1:0]   ax_ff, ay_ff, ax_in, ay_in;
   logic [2*ABS_W-1:0] px, py;
   logic [SQ_W-1:0]    sq_in;
   logic               sat_ff;
   logic [SRC_W-1:0]   src_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [REM_W+1:0]   rem_t, trial;
   logic               fits;

   assign ax_in = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
   assign ay_in = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
   assign px    = ax_ff * ax_ff;
   assign py    = ay_ff * ay_ff;
   assign sq_in = SQ_W'(px) + SQ_W'(py);

   // one result bit per step: bring down two bits, try (root << 2) | 1
   assign rem_t = {rem_ff, src_ff[SRC_W-1 -: 2]};
   assign trial = (REM_W+2)'({root_ff, 2'b01});
   assign fits  = rem_t >= trial;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      if (ctrl.square) begin
         sat_ff  <= sq_in > SAT_LIMIT;
         src_ff  <= sq_in[SRC_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctrl.step) begin
         src_ff  <= {src_ff[SRC_W-3:0], 2'b00};
         rem_ff  <= fits ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   // remainder above root means s > r*r + r, so round up
   always_comb begin
      if (sat_ff) begin
         mag = MAG_MAX;
      end else if (rem_ff > REM_W'(root_ff)) begin
         mag = root_ff + 1'b1;
      end else begin
         mag = root_ff;
      end
   end

endmodule

/* src/sobel_edge_magnitude_rgb_top.sv */
// Top level of the streaming RGB Sobel edge-magnitude block.
`timescale 1ns / 1ps

// Channel | Ports                           | One beat carries
// req     | req_valid, req_ready, req_data  | a pixel (cmd=0) or a drain tick (cmd=1)
// rsp     | rsp_valid, rsp_ready, rsp_data  | the red, green and blue edge magnitudes and frame_end
// csr     | csr_we, csr_index, csr_wdata    | one register write, taken at once
//
// Steps: a beat that yields a result goes through accept and line-buffer read,
//   line-buffer write and window shift, kernel sums, squares, 8 root steps and
//   result load; a beat with no result ends after the write and shift, and an
//   ignored drain tick is only accepted.
// Reset clears counters, window and result valid; the line buffer is not
//   cleared, since entries read before being written fall outside the frame.
// Stalls: the result register holds a finished beat while the next beat is
//   taken; a new result waits in its last state until that register is free.

module sobel_edge_magnitude_rgb_top #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sem_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sem_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [sem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sem_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned W_W   = COL_W + 1;
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 3);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_SOBEL  = 3'd2;
   localparam logic [2:0] ST_SQUARE = 3'd3;
   localparam logic [2:0] ST_ROOT   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]        in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   pix_type                 pix_ff, pix_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    frame_end_ff, frame_end_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [W_W-1:0]     used_w;
   logic [ROW_W-1:0]   used_h;
   logic               req_accept, drain, req_ignore;
   logic               col_wrap, started, last, csr_hit;
   win_mask_type       mask;
   win_ctrl_type       win_ctrl;
   mag_ctrl_type       mag_ctrl;
   logic               mem_rd_en, mem_wr_en;
   logic [LINE_W-1:0]  mem_rd_data;
   grad_type           gx [NUM_CH];
   grad_type           gy [NUM_CH];
   logic [ROOT_W-1:0]  mag [NUM_CH];

   // Frame size clamped to 1..MAX
   always_comb begin
      if (width_ff == '0) begin
         used_w = W_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         used_w = W_W'(MAX_WIDTH);
      end else begin
         used_w = W_W'(width_ff);
      end
      if (height_ff == '0) begin
         used_h = ROW_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         used_h = ROW_W'(MAX_HEIGHT);
      end else begin
         used_h = ROW_W'(height_ff);
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   // past the last row every beat is a drain beat; a tick before that does nothing
   assign drain      = in_row_ff >= used_h;
   assign req_ignore = req_data.cmd && !drain;

   assign col_wrap = ({1'b0, in_col_ff} + W_W'(1)) >= used_w;
   // first result once the input reaches row 1, column 1 (window centered on 0,0)
   assign started  = (in_row_ff >= ROW_W'(2)) ||
                     ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));

   // zero padding at the frame borders, by output position
   assign mask.left_ok   = out_col_ff != '0;
   assign mask.right_ok  = ({1'b0, out_col_ff} + W_W'(1)) < used_w;
   assign mask.top_ok    = out_row_ff != '0;
   assign mask.bottom_ok = (out_row_ff + ROW_W'(1)) < used_h;
   assign last           = !mask.right_ok && !mask.bottom_ok;

   assign csr_hit = csr_we && ((csr_index == REG_IMAGE_WIDTH) ||
                               (csr_index == REG_IMAGE_HEIGHT));

   // Line buffer read on accept, write-back in the following cycle in ST_UPDATE.
   // The FSM never overlaps them, so no forwarding path is needed.
   assign mem_rd_en = req_accept;
   assign mem_wr_en = (state_ff == ST_UPDATE);

   assign win_ctrl.shift = (state_ff == ST_UPDATE);
   assign win_ctrl.clear = csr_hit || ((state_ff == ST_SOBEL) && last);

   assign mag_ctrl.load   = (state_ff == ST_SOBEL);
   assign mag_ctrl.square = (state_ff == ST_SQUARE);
   assign mag_ctrl.step   = (state_ff == ST_ROOT);

   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pix_in       = pix_ff;
      step_in      = step_ff;
      frame_end_in = frame_end_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && !req_ignore) begin
               pix_in   = drain ? '0 : {req_data.pixel_blue, req_data.pixel_green,
                                        req_data.pixel_red};
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            state_in = started ? ST_SOBEL : ST_IDLE;
         end
         ST_SOBEL: begin
            frame_end_in = last;
            if (mask.right_ok) begin
               out_col_in = out_col_ff + 1'b1;
            end else begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end
            // frame done: next beat starts a new frame
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{edge_red:   mag[0],
                                edge_green: mag[1],
                                edge_blue:  mag[2],
                                frame_end:  frame_end_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes must arrive only while idle (the block does not enforce it); any write restarts the frame
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
      if (csr_hit) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      pix_ff       <= pix_in;
      frame_end_ff <= frame_end_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sem_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (in_col_ff),
      .wr_data ({mem_rd_data[PIX_W-1:0], pix_ff})
   );

   sem_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win_ctrl),
      .top_pix (mem_rd_data[LINE_W-1:PIX_W]),
      .mid_pix (mem_rd_data[PIX_W-1:0]),
      .new_pix (pix_ff),
      .mask    (mask),
      .gx      (gx),
      .gy      (gy)
   );

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_mag
      sem_mag u_mag (
         .clock (clock),
         .ctrl  (mag_ctrl),
         .gx    (gx[ch]),
         .gy    (gy[ch]),
         .mag   (mag[ch])
      );
   end

   // ---- assertions ----
   a_in_col_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, in_col_ff} < used_w)
      else $error("input column at or past frame width");

   a_out_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (out_row_ff < used_h) && ({1'b0, out_col_ff} < used_w))
      else $error("output position outside frame");

   a_restart_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SOBEL) && last && !csr_we |=>
      (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
      else $error("counters not cleared after last pixel of frame");

   a_mem_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("line buffer read and write in the same cycle");

endmodule
